// File: rtl/core/tcp_pkg.sv
// Types and constants shared by the tone cadence player modules.
// Depends on nothing; every other file of the block but tcp_if imports it.
package tcp_pkg;

  localparam int OPCODE_W = 2;
  localparam int SEG_IDX_W = 4;
  localparam int DUR_W = 16;
  localparam int WADDR_W = 13;
  localparam int SAMPLE_W = 16;
  localparam int PASS_W = 8;

  localparam logic [DUR_W-1:0] STOP_LENGTH = 16'd32000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 2'd0,
    OP_SEG_WR   = 2'd1,
    OP_WAVE_WR  = 2'd2,
    OP_RESTART  = 2'd3
  } tcp_op_t;

  // One segment table entry.
  typedef struct packed {
    logic [DUR_W-1:0]   dur;
    logic               rpt;
    logic               rep;
    logic [WADDR_W-1:0] base;
    logic [WADDR_W-1:0] len;
  } tcp_seg_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_CUR,
    RD_WALK
  } tcp_rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RST_LD,
    ST_WALK_RD,
    ST_WALK_EVAL,
    ST_FINAL_EVAL,
    ST_STOP,
    ST_SEG_RD,
    ST_SEG_EVAL,
    ST_EMIT_PLAY,
    ST_EMIT_IDLE
  } tcp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        req_ready;
    logic        restart_init;
    logic        load_len0;
    tcp_rd_sel_t tbl_sel;
    logic        walk_init;
    logic        walk_step;
    logic        commit;
    logic        stop;
    logic        seg_eval;
    logic        emit_idle;
    logic        emit_play;
  } tcp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    req_valid;
    tcp_op_t req_op;
    logic    active;
    logic    sc_ge_len;
    logic    t_eq_start;
    logic    limit_hit;
    logic    ev_stop;
    logic    ev_break;
    logic    fin_stop;
    logic    res_free;
  } tcp_stat_t;

endpackage

// File: rtl/core/tcp_if.sv
// Handshake channels of the tone cadence player: request, result and configuration.
// Depends on nothing; the widths are those of the item fields.
interface tcp_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [3:0]         seg_index;
  logic [15:0]        seg_duration;
  logic               seg_repeat_point;
  logic               seg_replay;
  logic [12:0]        seg_wave_base;
  logic [12:0]        seg_wave_len;
  logic [12:0]        wave_addr;
  logic signed [15:0] wave_value;

  modport source (
    output valid, opcode, seg_index, seg_duration, seg_repeat_point, seg_replay,
           seg_wave_base, seg_wave_len, wave_addr, wave_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, seg_index, seg_duration, seg_repeat_point, seg_replay,
           seg_wave_base, seg_wave_len, wave_addr, wave_value,
    output ready
  );
endinterface

interface tcp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic [3:0]         segment_now;
  logic               playing;
  logic               segment_begun;

  modport source (
    output valid, sample_out, segment_now, playing, segment_begun,
    input  ready
  );
  modport sink (
    input  valid, sample_out, segment_now, playing, segment_begun,
    output ready
  );
endinterface

interface tcp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] pass_limit;

  modport source (output valid, pass_limit, input ready);
  modport sink (input valid, pass_limit, output ready);
endinterface

// File: rtl/core/tcp_ctrl.sv
// Controller state machine of the tone cadence player.
// Depends on tcp_pkg; drives the datapath through tcp_ctl_t and reads tcp_stat_t.
module tcp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  tcp_pkg::tcp_stat_t stat,
  output tcp_pkg::tcp_ctl_t  ctl
);
  import tcp_pkg::*;

  tcp_state_t state;
  tcp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.req_valid) begin
          case (stat.req_op)
            OP_RESTART: state_next = ST_RST_LD;
            OP_TICK: begin
              if (!stat.active) begin
                state_next = ST_EMIT_IDLE;
              end else if (stat.sc_ge_len) begin
                state_next = ST_WALK_RD;
              end else begin
                state_next = ST_SEG_RD;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_RST_LD: state_next = ST_IDLE;
      ST_WALK_RD: begin
        if (stat.t_eq_start) begin
          state_next = ST_FINAL_EVAL;
        end else if (stat.limit_hit) begin
          state_next = ST_STOP;
        end else begin
          state_next = ST_WALK_EVAL;
        end
      end
      ST_WALK_EVAL: begin
        if (stat.ev_stop) begin
          state_next = ST_STOP;
        end else if (stat.ev_break) begin
          state_next = ST_FINAL_EVAL;
        end else begin
          state_next = ST_WALK_RD;
        end
      end
      ST_FINAL_EVAL: state_next = stat.fin_stop ? ST_STOP : ST_SEG_RD;
      ST_STOP:       state_next = ST_EMIT_IDLE;
      ST_SEG_RD:     state_next = ST_SEG_EVAL;
      ST_SEG_EVAL:   state_next = ST_EMIT_PLAY;
      ST_EMIT_PLAY:  state_next = stat.res_free ? ST_IDLE : ST_EMIT_PLAY;
      ST_EMIT_IDLE:  state_next = stat.res_free ? ST_IDLE : ST_EMIT_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.tbl_sel = RD_ZERO;
    case (state)
      ST_IDLE: begin
        ctl.req_ready = 1'b1;
        if (stat.req_valid && stat.req_op == OP_RESTART) begin
          ctl.restart_init = 1'b1;
        end
        if (stat.req_valid && stat.req_op == OP_TICK && stat.active && stat.sc_ge_len) begin
          ctl.walk_init = 1'b1;
        end
      end
      ST_RST_LD:     ctl.load_len0 = 1'b1;
      ST_WALK_RD:    ctl.tbl_sel = RD_WALK;
      ST_WALK_EVAL: begin
        ctl.tbl_sel = RD_WALK;
        ctl.walk_step = 1'b1;
      end
      ST_FINAL_EVAL: begin
        ctl.tbl_sel = RD_WALK;
        ctl.commit = !stat.fin_stop;
      end
      ST_STOP:       ctl.stop = 1'b1;
      ST_SEG_RD:     ctl.tbl_sel = RD_CUR;
      ST_SEG_EVAL:   ctl.seg_eval = 1'b1;
      ST_EMIT_PLAY:  ctl.emit_play = stat.res_free;
      ST_EMIT_IDLE:  ctl.emit_idle = stat.res_free;
      default:       ctl = '0;
    endcase
  end

endmodule

// File: rtl/core/tcp_datapath.sv
// Datapath of the tone cadence player: segment table, wave memory, play state
// and the result register. Depends on tcp_pkg and the channels in tcp_if.
module tcp_datapath #(
  parameter int SEGMENTS    = 16,
  parameter int WAVE_DEPTH  = 8192,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  tcp_req_if.sink            req,
  tcp_rsp_if.source          rsp,
  tcp_cfg_if.sink            cfg,
  input  tcp_pkg::tcp_ctl_t  ctl,
  output tcp_pkg::tcp_stat_t stat
);
  import tcp_pkg::*;

  localparam int SEG_W      = $clog2(SEGMENTS);
  localparam int WAVE_AW    = $clog2(WAVE_DEPTH);
  localparam int WALK_LIMIT = 2 * SEGMENTS + 2;
  localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
  localparam int NUM_IDX    = 1 << SEG_IDX_W;

  // Write indexes reduced modulo the table depth, worked out at elaboration.
  logic [SEG_W-1:0] seg_wrap [NUM_IDX];
  for (genvar g = 0; g < NUM_IDX; g++) begin : g_wrap
    assign seg_wrap[g] = SEG_W'(g % SEGMENTS);
  end

  tcp_seg_t               seg_mem [SEGMENTS];
  logic [SAMPLE_BITS-1:0] wave_mem [WAVE_DEPTH];

  tcp_seg_t               tbl_q;
  logic [SAMPLE_BITS-1:0] wave_q;
  logic [SEG_W-1:0]       tbl_addr;
  logic [WAVE_AW-1:0]     wave_rd_addr;

  logic [SEG_W-1:0]   cur;
  logic [SEG_W-1:0]   loop_start;
  logic [DUR_W-1:0]   sample_count;
  logic [DUR_W-1:0]   segment_length;
  logic [WADDR_W-1:0] wave_pos;
  logic               first_pass;
  logic [PASS_W-1:0]  passes_left;
  logic               active;
  logic [PASS_W-1:0]  pass_limit;
  logic [SEG_W-1:0]   walk_t;
  logic [STEP_W-1:0]  steps;
  logic               begun_q;
  logic               silent_q;

  logic                     res_valid;
  logic signed [SAMPLE_W-1:0] res_sample;
  logic [SEG_IDX_W-1:0]     res_seg;
  logic                     res_play;
  logic                     res_begun;

  logic               accept;
  tcp_op_t            req_op;
  logic [WADDR_W-1:0] wp_eff;
  logic [WADDR_W:0]   wave_sum;
  logic [SEG_W-1:0]   walk_t_inc;
  logic [SEG_W-1:0]   cur_seg_now;

  assign req_op = tcp_op_t'(req.opcode);
  assign accept = req.valid && ctl.req_ready;
  assign req.ready = ctl.req_ready;
  assign cfg.ready = 1'b1;

  assign walk_t_inc = (walk_t == SEG_W'(SEGMENTS - 1)) ? '0 : walk_t + 1'b1;

  always_comb begin
    case (ctl.tbl_sel)
      RD_ZERO: tbl_addr = '0;
      RD_CUR:  tbl_addr = cur;
      RD_WALK: tbl_addr = walk_t;
      default: tbl_addr = '0;
    endcase
  end

  // Slice position restarts at one when it is zero or has run past the slice length.
  assign wp_eff   = (wave_pos == '0 || wave_pos > tbl_q.len) ? WADDR_W'(1) : wave_pos;
  assign wave_sum = {1'b0, tbl_q.base} + {1'b0, wp_eff} - 1'b1;
  assign wave_rd_addr = WAVE_AW'(wave_sum);

  always_ff @(posedge clk) begin
    if (accept && req_op == OP_SEG_WR) begin
      seg_mem[seg_wrap[req.seg_index]] <= '{dur:  req.seg_duration,
                                            rpt:  req.seg_repeat_point,
                                            rep:  req.seg_replay,
                                            base: req.seg_wave_base,
                                            len:  req.seg_wave_len};
    end
    tbl_q <= seg_mem[tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && req_op == OP_WAVE_WR) begin
      wave_mem[WAVE_AW'(req.wave_addr)] <= req.wave_value[SAMPLE_BITS-1:0];
    end
    if (ctl.seg_eval) begin
      wave_q <= wave_mem[wave_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_limit <= '0;
    end else if (cfg.valid) begin
      pass_limit <= cfg.pass_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur            <= '0;
      loop_start     <= '0;
      sample_count   <= '0;
      segment_length <= '0;
      wave_pos       <= WADDR_W'(1);
      first_pass     <= 1'b1;
      passes_left    <= '0;
      active         <= 1'b0;
      walk_t         <= '0;
      steps          <= '0;
      begun_q        <= 1'b0;
      silent_q       <= 1'b1;
    end else begin
      if (ctl.restart_init) begin
        active       <= 1'b1;
        cur          <= '0;
        loop_start   <= '0;
        first_pass   <= 1'b1;
        passes_left  <= pass_limit;
        sample_count <= '0;
        wave_pos     <= WADDR_W'(1);
      end
      if (ctl.load_len0) begin
        segment_length <= tbl_q.dur;
      end
      if (ctl.walk_init) begin
        walk_t <= (cur == SEG_W'(SEGMENTS - 1)) ? '0 : cur + 1'b1;
        steps  <= '0;
      end
      if (ctl.walk_step) begin
        steps <= steps + 1'b1;
        if (tbl_q.dur == '0) begin
          // End marker: one pass used up, back to the loop start.
          if (passes_left != '0) begin
            passes_left <= passes_left - 1'b1;
          end
          if (!stat.ev_stop) begin
            walk_t     <= loop_start;
            first_pass <= 1'b0;
          end
        end else if (!(first_pass || tbl_q.rep)) begin
          walk_t <= walk_t_inc;
        end
      end
      if (ctl.commit) begin
        if (walk_t != cur) begin
          wave_pos <= WADDR_W'(1);
        end
        cur            <= walk_t;
        segment_length <= tbl_q.dur;
        sample_count   <= '0;
        if (tbl_q.rpt) begin
          loop_start <= walk_t;
        end
      end
      if (ctl.stop) begin
        active         <= 1'b0;
        segment_length <= STOP_LENGTH;
        sample_count   <= '0;
        wave_pos       <= WADDR_W'(1);
      end
      if (ctl.seg_eval) begin
        begun_q      <= (sample_count == '0);
        silent_q     <= (tbl_q.len == '0);
        sample_count <= sample_count + 1'b1;
        wave_pos     <= ((tbl_q.len != '0) ? wp_eff : wave_pos) + 1'b1;
      end
    end
  end

  assign cur_seg_now = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit_idle || ctl.emit_play) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_idle) begin
      res_sample <= '0;
      res_seg    <= SEG_IDX_W'(cur_seg_now);
      res_play   <= 1'b0;
      res_begun  <= 1'b0;
    end else if (ctl.emit_play) begin
      res_sample <= silent_q ? '0 : SAMPLE_W'($signed(wave_q));
      res_seg    <= SEG_IDX_W'(cur_seg_now);
      res_play   <= 1'b1;
      res_begun  <= begun_q;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.sample_out    = res_sample;
  assign rsp.segment_now   = res_seg;
  assign rsp.playing       = res_play;
  assign rsp.segment_begun = res_begun;

  always_comb begin
    stat.req_valid  = req.valid;
    stat.req_op     = req_op;
    stat.active     = active;
    stat.sc_ge_len  = (sample_count >= segment_length);
    stat.t_eq_start = (walk_t == cur);
    stat.limit_hit  = (steps >= STEP_W'(WALK_LIMIT));
    stat.ev_stop    = (tbl_q.dur == '0) && (passes_left == PASS_W'(1));
    stat.ev_break   = (tbl_q.dur != '0) && (first_pass || tbl_q.rep);
    stat.fin_stop   = (tbl_q.dur == '0) ||
                      ((walk_t == cur) && !first_pass && !tbl_q.rep);
    stat.res_free   = !res_valid || rsp.ready;
  end

endmodule

// File: rtl/core/tone_cadence_player_core.sv
// Tone cadence player: when the segment carries on, a tick passes SEG_RD and SEG_EVAL, its
// result is registered in EMIT_PLAY and the next item is then taken in IDLE. A segment change
// walks the table one entry at a time (WALK_RD, then WALK_EVAL) through its single read port.
// Writes are done in IDLE; a restart also passes RST_LD. One item is worked on at a time; a
// result left waiting in the result register holds the controller in its emit state and so
// holds back every later item. Synchronous reset clears the play state to idle (stopped until
// restart) and pass_limit to 0; the segment table and wave memory hold no reset value.
module tone_cadence_player_core #(
  parameter int SEGMENTS    = 16,
  parameter int WAVE_DEPTH  = 8192,
  parameter int SAMPLE_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  tcp_req_if.sink   req,
  tcp_rsp_if.source rsp,
  tcp_cfg_if.sink   cfg
);
  import tcp_pkg::*;

  tcp_ctl_t  ctl;
  tcp_stat_t stat;

  tcp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  tcp_datapath #(
    .SEGMENTS    (SEGMENTS),
    .WAVE_DEPTH  (WAVE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg),
    .ctl  (ctl),
    .stat (stat)
  );

endmodule

// File: tb/sv/tcp_cadence_checker.sv
`timescale 1ns / 100ps
// Checker for the tone cadence player: follows every transfer on the three channels,
// predicts the sample that each tick yields and compares it with what the block returns.
// Depends on tcp_pkg and on the channel interfaces in tcp_if.sv.
module tcp_cadence_checker (
  input  logic clk,
  input  logic rst,
  tcp_req_if   req,
  tcp_rsp_if   rsp,
  tcp_cfg_if   cfg,
  output int   fails,
  output int   backlog,
  output int   results_checked,
  output int   segment_starts,
  output int   idle_results
);
  import tcp_pkg::*;

  localparam int NUM_SEGS   = 16;
  localparam int WAVE_WORDS = 8192;
  localparam int WALK_STEPS = 2 * NUM_SEGS + 2;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         seg;
    logic               playing;
    logic               begun;
  } tone_out_t;

  // Own copy of the cadence state.
  tcp_seg_t    seg_tab [NUM_SEGS];
  logic [15:0] wave_mem [WAVE_WORDS];
  logic [7:0]  pass_limit;
  logic [7:0]  passes_left;
  logic [3:0]  cur_seg;
  logic [3:0]  loop_seg;
  logic [15:0] samp_cnt;
  logic [15:0] seg_dur_now;
  logic [12:0] wpos;
  bit          first_pass;
  bit          running;

  tone_out_t samples_due[$];
  tone_out_t got_tone;
  tone_out_t due_tone;

  initial begin
    fails = 0;
    backlog = 0;
    results_checked = 0;
    segment_starts = 0;
    idle_results = 0;
  end

  function automatic void halt_cadence();
    running = 1'b0;
    seg_dur_now = STOP_LENGTH;
    samp_cnt = '0;
    wpos = 13'd1;
  endfunction

  // Moves on to the next playable segment; returns 0 when playback has stopped.
  function automatic bit walk_to_next_segment();
    int start;
    int t;
    int steps;
    start = cur_seg;
    t = (start + 1) % NUM_SEGS;
    steps = 0;
    while (t != start) begin
      if (steps >= WALK_STEPS) begin
        halt_cadence();
        return 1'b0;
      end
      steps++;
      if (seg_tab[t].dur == '0) begin
        if (passes_left != 0) begin
          passes_left = passes_left - 8'd1;
          if (passes_left == 0) begin
            halt_cadence();
            return 1'b0;
          end
        end
        t = loop_seg;
        first_pass = 1'b0;
        continue;
      end
      if (first_pass || seg_tab[t].rep)
        break;
      t = (t + 1) % NUM_SEGS;
    end
    if (seg_tab[t].dur == '0 || (t == start && !first_pass && !seg_tab[t].rep)) begin
      halt_cadence();
      return 1'b0;
    end
    // Landing on the segment just left keeps the wavetable position.
    if (t != start)
      wpos = 13'd1;
    cur_seg = 4'(t);
    seg_dur_now = seg_tab[t].dur;
    if (seg_tab[t].rpt)
      loop_seg = 4'(t);
    samp_cnt = '0;
    return 1'b1;
  endfunction

  function automatic tone_out_t play_tick();
    tone_out_t o;
    logic [12:0] addr;
    o.sample = '0;
    o.seg = cur_seg;
    o.playing = 1'b0;
    o.begun = 1'b0;
    if (!running)
      return o;
    if (samp_cnt >= seg_dur_now) begin
      if (!walk_to_next_segment())
        return o;
    end
    o.begun = (samp_cnt == 0);
    if (seg_tab[cur_seg].len != '0) begin
      if (wpos == '0 || wpos > seg_tab[cur_seg].len)
        wpos = 13'd1;
      addr = seg_tab[cur_seg].base + wpos - 13'd1;
      o.sample = wave_mem[addr];
    end
    o.seg = cur_seg;
    o.playing = 1'b1;
    samp_cnt = samp_cnt + 16'd1;
    wpos = wpos + 13'd1;
    return o;
  endfunction

  function automatic string tone_text(input tone_out_t t);
    return $sformatf("sample %0d segment %0d playing %0b begun %0b",
                     $signed(t.sample), t.seg, t.playing, t.begun);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pass_limit = '0;
      passes_left = '0;
      cur_seg = '0;
      loop_seg = '0;
      samp_cnt = '0;
      seg_dur_now = '0;
      wpos = 13'd1;
      first_pass = 1'b1;
      running = 1'b0;
      samples_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got_tone.sample = rsp.sample_out;
        got_tone.seg = rsp.segment_now;
        got_tone.playing = rsp.playing;
        got_tone.begun = rsp.segment_begun;
        results_checked++;
        if (got_tone.begun === 1'b1)
          segment_starts++;
        if (got_tone.playing !== 1'b1)
          idle_results++;
        if (samples_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with no tick outstanding: %s", $time, tone_text(got_tone));
        end else begin
          due_tone = samples_due.pop_front();
          if (got_tone.sample !== due_tone.sample || got_tone.seg !== due_tone.seg ||
              got_tone.playing !== due_tone.playing || got_tone.begun !== due_tone.begun) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch, expected %s", $time, tone_text(due_tone));
              $display("%0t:           got      %s", $time, tone_text(got_tone));
            end
          end
        end
      end
      if (cfg.valid && cfg.ready)
        pass_limit = cfg.pass_limit;
      if (req.valid && req.ready) begin
        case (req.opcode)
          OP_SEG_WR: begin
            seg_tab[req.seg_index].dur = req.seg_duration;
            seg_tab[req.seg_index].rpt = req.seg_repeat_point;
            seg_tab[req.seg_index].rep = req.seg_replay;
            seg_tab[req.seg_index].base = req.seg_wave_base;
            seg_tab[req.seg_index].len = req.seg_wave_len;
          end
          OP_WAVE_WR: wave_mem[req.wave_addr] = req.wave_value;
          OP_RESTART: begin
            running = 1'b1;
            cur_seg = '0;
            loop_seg = '0;
            first_pass = 1'b1;
            passes_left = pass_limit;
            samp_cnt = '0;
            wpos = 13'd1;
            seg_dur_now = seg_tab[0].dur;
          end
          default: samples_due.push_back(play_tick());
        endcase
      end
    end
    backlog = samples_due.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the tone cadence player testbench: clock, reset, request and configuration
// stimulus, result back-pressure, watchdog and verdict. Depends on tcp_pkg, tcp_if.sv,
// tone_cadence_player_core and tcp_cadence_checker.
module tb_top;
  import tcp_pkg::*;

  // Every sample that can be played is read from this small wave window, which wraps past
  // the top of the wave memory; it is loaded before anything is played.
  localparam int WIN_FIRST     = 8188;
  localparam int WIN_WORDS     = 12;
  localparam int RANDOM_ITEMS  = 460;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 3000;

  typedef struct packed {
    tcp_op_t            op;
    logic [3:0]         idx;
    logic [15:0]        dur;
    logic               rpt;
    logic               rep;
    logic [12:0]        base;
    logic [12:0]        len;
    logic [12:0]        waddr;
    logic signed [15:0] wval;
  } cadence_req_t;

  logic clk;
  logic rst;
  int   fails;
  int   backlog;
  int   results_checked;
  int   segment_starts;
  int   idle_results;
  int   items_sent = 0;
  int   burst_left = 0;
  int   settings_used = 0;
  int   quiet_cycles = 0;

  tcp_req_if req_ch ();
  tcp_rsp_if rsp_ch ();
  tcp_cfg_if cfg_ch ();

  tone_cadence_player_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  tcp_cadence_checker cadence_chk (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch),
    .fails(fails),
    .backlog(backlog),
    .results_checked(results_checked),
    .segment_starts(segment_starts),
    .idle_results(idle_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: each stretch of cycles follows one of a few stall patterns.
  initial begin
    int mode;
    int span;
    int k;
    rsp_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: rsp_ch.ready = 1'b1;
          1: rsp_ch.ready = ($urandom_range(0, 1) == 1);
          2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready = (k % 9 == 8);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles without a transfer.", quiet_cycles);
      $display("FAIL tone_cadence_player_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Fields that the operation does not use are left random.
  function automatic cadence_req_t any_req(input tcp_op_t op);
    cadence_req_t r;
    r.op = op;
    r.idx = 4'($urandom);
    r.dur = 16'($urandom);
    r.rpt = 1'($urandom);
    r.rep = 1'($urandom);
    r.base = 13'($urandom);
    r.len = 13'($urandom);
    r.waddr = 13'($urandom);
    r.wval = 16'($urandom);
    return r;
  endfunction

  function automatic cadence_req_t seg_req(input logic [3:0] idx, input logic [15:0] dur,
                                           input logic rpt, input logic rep,
                                           input logic [12:0] base, input logic [12:0] len);
    cadence_req_t r;
    r = any_req(OP_SEG_WR);
    r.idx = idx;
    r.dur = dur;
    r.rpt = rpt;
    r.rep = rep;
    r.base = base;
    r.len = len;
    return r;
  endfunction

  function automatic cadence_req_t wave_req(input logic [12:0] addr,
                                            input logic signed [15:0] val);
    cadence_req_t r;
    r = any_req(OP_WAVE_WR);
    r.waddr = addr;
    r.wval = val;
    return r;
  endfunction

  // A segment with random flags; a playable one always gets a slice inside the window.
  function automatic cadence_req_t random_seg(input logic [3:0] idx, input bit may_end);
    cadence_req_t r;
    int off;
    r = any_req(OP_SEG_WR);
    r.idx = idx;
    if (may_end && $urandom_range(0, 9) == 0)
      r.dur = '0;
    else if ($urandom_range(0, 24) == 0)
      r.dur = 16'($urandom);
    else
      r.dur = 16'($urandom_range(1, 6));
    if (r.dur != '0) begin
      off = $urandom_range(0, WIN_WORDS - 1);
      r.base = 13'(WIN_FIRST + off);
      r.len = 13'($urandom_range(0, WIN_WORDS - off));
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer with valid
  // still high, so that back-to-back items keep valid asserted.
  task automatic send(input cadence_req_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    req_ch.valid = 1'b1;
    req_ch.opcode = it.op;
    req_ch.seg_index = it.idx;
    req_ch.seg_duration = it.dur;
    req_ch.seg_repeat_point = it.rpt;
    req_ch.seg_replay = it.rep;
    req_ch.seg_wave_base = it.base;
    req_ch.seg_wave_len = it.len;
    req_ch.wave_addr = it.waddr;
    req_ch.wave_value = it.wval;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  // Lets every outstanding result arrive and the block finish any write or restart.
  task automatic wait_quiet();
    req_ch.valid = 1'b0;
    burst_left = 0;
    while (backlog != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_pass_limit(input logic [7:0] v);
    cfg_ch.valid = 1'b1;
    cfg_ch.pass_limit = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    settings_used++;
  endtask

  initial begin
    int i;
    int k;
    int episode;
    int first_random;
    int pick;
    logic signed [15:0] val;
    cadence_req_t r;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_TICK;
    req_ch.seg_index = '0;
    req_ch.seg_duration = '0;
    req_ch.seg_repeat_point = 1'b0;
    req_ch.seg_replay = 1'b0;
    req_ch.seg_wave_base = '0;
    req_ch.seg_wave_len = '0;
    req_ch.wave_addr = '0;
    req_ch.wave_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.pass_limit = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    write_pass_limit(8'd2);

    // Load the wave window, with the sample extremes first, and the whole segment table.
    for (i = 0; i < WIN_WORDS; i++) begin
      case (i)
        0: val = 16'sh7FFF;
        1: val = 16'sh8000;
        2: val = '0;
        3: val = -16'sd1;
        default: val = 16'($urandom);
      endcase
      send(wave_req(13'(WIN_FIRST + i), val));
    end
    send(seg_req(4'd0, 16'd2, 1'b0, 1'b1, 13'd8188, 13'd3));
    send(seg_req(4'd1, 16'd3, 1'b1, 1'b0, 13'd0, 13'd0));
    send(seg_req(4'd2, 16'd2, 1'b0, 1'b1, 13'd8190, 13'd5));
    send(seg_req(4'd3, 16'd0, 1'b1, 1'b1, 13'h1FFF, 13'h1FFF));
    for (i = 4; i < 15; i++) begin
      r = any_req(OP_SEG_WR);
      r.idx = 4'(i);
      r.dur = '0;
      send(r);
    end
    send(seg_req(4'd15, 16'hFFFF, 1'b1, 1'b1, 13'd8188, 13'd12));

    // Idle tick, then two passes: a silent repeat point, a slice wrapping past the top of
    // memory, the same segment entered again on the second pass, and the stop.
    send(any_req(OP_TICK));
    send(any_req(OP_RESTART));
    repeat (11) send(any_req(OP_TICK));

    // Endless repeats: the loop is cut under the playing segment so that the walk never
    // comes back to it and runs into its step limit.
    wait_quiet();
    write_pass_limit(8'd0);
    send(seg_req(4'd0, 16'd1, 1'b0, 1'b1, 13'd8188, 13'd2));
    send(seg_req(4'd1, 16'd1, 1'b1, 1'b0, 13'd8191, 13'd4));
    send(seg_req(4'd2, 16'd1, 1'b0, 1'b0, 13'd0, 13'd8));
    send(seg_req(4'd3, 16'd3, 1'b0, 1'b0, 13'd8188, 13'd12));
    send(seg_req(4'd4, 16'd0, 1'b0, 1'b0, 13'd100, 13'd4096));
    send(any_req(OP_RESTART));
    repeat (4) send(any_req(OP_TICK));
    send(seg_req(4'd2, 16'd0, 1'b0, 1'b0, 13'd4096, 13'd1));
    repeat (4) send(any_req(OP_TICK));
    // The walk returns to a segment that does not replay, which stops playback.
    send(any_req(OP_RESTART));
    repeat (3) send(any_req(OP_TICK));

    // Random cadences: a fresh table, a restart, then mostly ticks with stray writes and restarts.
    first_random = items_sent;
    episode = 0;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      if (episode < 2 || $urandom_range(0, 2) == 0) begin
        wait_quiet();
        case (episode)
          0: pick = 255;
          1: pick = 1;
          default: begin
            case ($urandom_range(0, 4))
              0: pick = 0;
              1: pick = 2;
              2: pick = 3;
              3: pick = 255;
              default: pick = $urandom_range(0, 255);
            endcase
          end
        endcase
        write_pass_limit(8'(pick));
      end
      if ($urandom_range(0, 3) == 0) begin
        // A full table, at times without an end marker, so the walk wraps round.
        for (i = 0; i < 16; i++)
          send(random_seg(4'(i), 1'b1));
      end else begin
        k = $urandom_range(2, 6);
        for (i = 0; i < k; i++)
          send(random_seg(4'(i), i != 0));
        r = any_req(OP_SEG_WR);
        r.idx = 4'(k);
        r.dur = '0;
        send(r);
      end
      send(any_req(OP_RESTART));
      repeat ($urandom_range(15, 60)) begin
        pick = $urandom_range(0, 99);
        if (pick < 82) begin
          r = any_req(OP_TICK);
        end else if (pick < 90) begin
          r = any_req(OP_WAVE_WR);
          if ($urandom_range(0, 3) != 0)
            r.waddr = 13'(WIN_FIRST + $urandom_range(0, WIN_WORDS - 1));
        end else if (pick < 96) begin
          r = random_seg(4'($urandom), 1'b1);
        end else begin
          r = any_req(OP_RESTART);
        end
        send(r);
      end
      episode++;
    end

    wait_quiet();
    $display("Sent %0d items over %0d cadences; checked %0d results.",
             items_sent, episode + 3, results_checked);
    $display("Saw %0d segment entries, %0d silent idle results, %0d pass_limit settings.",
             segment_starts, idle_results, settings_used);
    if (fails == 0 && backlog == 0)
      $display("PASS tone_cadence_player_core");
    else
      $display("FAIL tone_cadence_player_core");
    $finish;
  end

endmodule
